// ===== hdl/tsbt_pkg.sv =====
// Shared types, constants and hash helpers for the TCP SYN Bloom tracker.
// No dependencies; every other file of the block imports this package.
package tsbt_pkg;

	// Filter geometry and probe count.
	localparam int FILTER_BITS  = 4096;
	localparam int PROBE_COUNT  = 3;
	localparam int WORD_BITS    = 64;
	localparam int POS_W        = 6;
	localparam int FILTER_WORDS = FILTER_BITS / WORD_BITS;
	localparam int BIT_W        = $clog2(FILTER_BITS);
	localparam int ADDR_W       = (FILTER_WORDS > 1) ? $clog2(FILTER_WORDS) : 1;
	localparam int PROBE_W      = (PROBE_COUNT > 1) ? $clog2(PROBE_COUNT) : 1;
	localparam logic [BIT_W-1:0] BIT_MASK = BIT_W'(FILTER_BITS - 1);

	// Number of 32-bit keys hashed per flow: source, destination, ports.
	localparam int FIELD_COUNT = 3;

	// Request queue between the hash front and the filter back.
	localparam int Q_DEPTH = 4;
	localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	// Mixer and seed constants.
	localparam logic [31:0] MIX_MUL_A = 32'h7feb352d;
	localparam logic [31:0] MIX_MUL_B = 32'h846ca68b;
	localparam logic [31:0] SEED_STEP = 32'h9e3779b9;
	localparam logic [31:0] PROTO_TCP = 32'd6;

	// Operation decided by the front for each request.
	typedef enum logic [1:0] {
		OP_IGNORE,
		OP_RECORD,
		OP_CHECK,
		OP_OTHER
	} op_t;

	// Result class codes.
	typedef enum logic [2:0] {
		CLS_IGNORED     = 3'd0,
		CLS_SYN         = 3'd1,
		CLS_SOLICITED   = 3'd2,
		CLS_UNSOLICITED = 3'd3,
		CLS_OTHER       = 3'd4
	} cls_t;

	// Back-end sequencer states.
	typedef enum logic [1:0] {
		B_IDLE,
		B_READ,
		B_MERGE,
		B_FINISH
	} back_state_t;

	// One request as it travels through the queue.
	typedef struct packed {
		op_t                               op;
		logic [PROBE_COUNT-1:0][BIT_W-1:0] bit_idx;
	} probe_req_t;

	// Queue status seen by the back end and the checks.
	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	// First mixer step: fold and multiply.
	function automatic logic [31:0] mix_a(input logic [31:0] x);
		logic [31:0] y;
		y = x ^ (x >> 16);
		return y * MIX_MUL_A;
	endfunction

	// Second mixer step: fold and multiply.
	function automatic logic [31:0] mix_b(input logic [31:0] x);
		logic [31:0] y;
		y = x ^ (x >> 15);
		return y * MIX_MUL_B;
	endfunction

	// Final mixer step: fold only.
	function automatic logic [31:0] mix_c(input logic [31:0] x);
		return x ^ (x >> 16);
	endfunction

	// Whole mixer, used only for constants at elaboration.
	function automatic logic [31:0] mix_full(input logic [31:0] x);
		return mix_c(mix_b(mix_a(x)));
	endfunction

	// Seed of probe number i.
	function automatic logic [31:0] probe_seed(input int i);
		logic [31:0] k;
		k = 32'(i + 1);
		return SEED_STEP * k;
	endfunction

	// Mixed protocol number, the same for every TCP flow.
	localparam logic [31:0] MIX_TCP = mix_full(PROTO_TCP);

endpackage

// ===== hdl/tcp_syn_bloom_tracker_core.sv =====
// Top level of the TCP SYN Bloom tracker: hash front, request queue, filter back end.
// Depends on tsbt_pkg, tsbt_front, tsbt_queue and tsbt_back.
//
// Channel   Handshake              Payload
// request   start / busy           is_ipv4_tcp, src_addr, dst_addr, src_tcp_port,
//                                  dst_tcp_port, syn_flag, ack_flag
// result    done (one-cycle pulse) packet_class, syn_total, solicited_total,
//                                  unsolicited_total, other_total
//
// A request is taken at a rising edge with start high and busy low; the four-stage hash
// pipeline and the queue admit up to four requests in flight, so busy rises only when
// the filter side falls behind. The filter side sets the rate: an ignored or other packet
// passes an idle and a finish step, a SYN or SYN+ACK also a read and a merge step per
// probe on the single filter port, one request at a time. Reset is asynchronous and takes
// effect at once: per-word valid bits make the filter read as cleared, with no sweep.
// The result is shown for exactly one cycle with done high; the receiver cannot stall.
module tcp_syn_bloom_tracker_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        is_ipv4_tcp,
	input  logic [31:0] src_addr,
	input  logic [31:0] dst_addr,
	input  logic [15:0] src_tcp_port,
	input  logic [15:0] dst_tcp_port,
	input  logic        syn_flag,
	input  logic        ack_flag,
	output logic        done,
	output logic [2:0]  packet_class,
	output logic [63:0] syn_total,
	output logic [63:0] solicited_total,
	output logic [63:0] unsolicited_total,
	output logic [63:0] other_total
);
	import tsbt_pkg::*;

	logic       q_push;
	logic       q_pop;
	probe_req_t push_req;
	probe_req_t head;
	q_status_t  q_status;

	// Classification and hashing.
	tsbt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.is_ipv4_tcp  (is_ipv4_tcp),
		.src_addr     (src_addr),
		.dst_addr     (dst_addr),
		.src_tcp_port (src_tcp_port),
		.dst_tcp_port (dst_tcp_port),
		.syn_flag     (syn_flag),
		.ack_flag     (ack_flag),
		.credit_ret   (q_pop),
		.push         (q_push),
		.push_req     (push_req)
	);

	// Decoupling queue.
	tsbt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_req (push_req),
		.pop      (q_pop),
		.head     (head),
		.q_status (q_status)
	);

	// Filter access and result.
	tsbt_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_status          (q_status),
		.head              (head),
		.pop               (q_pop),
		.done              (done),
		.packet_class      (packet_class),
		.syn_total         (syn_total),
		.solicited_total   (solicited_total),
		.unsolicited_total (unsolicited_total),
		.other_total       (other_total)
	);

	// The credit scheme must keep the queue from overflowing.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_status.full)
		else $error("request pushed into a full queue");

	// The back end never pops an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_status.empty)
		else $error("request popped from an empty queue");

	// Results are never reported in consecutive cycles.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// The SYN counter advances exactly when a SYN is reported.
	a_syn_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> syn_total == $past(syn_total) + 64'(packet_class == CLS_SYN))
		else $error("SYN total does not match the reported class");

endmodule

// ===== hdl/tsbt_front.sv =====
// Front end: accepts packets, classifies them and hashes the flow into probe bits.
// Depends on tsbt_pkg; feeds tsbt_queue and holds one credit per request in flight.
module tsbt_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                is_ipv4_tcp,
	input  logic [31:0]         src_addr,
	input  logic [31:0]         dst_addr,
	input  logic [15:0]         src_tcp_port,
	input  logic [15:0]         dst_tcp_port,
	input  logic                syn_flag,
	input  logic                ack_flag,
	input  logic                credit_ret,
	output logic                push,
	output tsbt_pkg::probe_req_t push_req
);
	import tsbt_pkg::*;

	logic              accept;
	op_t               op_in;
	logic [31:0]       key_in [FIELD_COUNT];
	logic [31:0]       base_hash;
	logic [QCNT_W-1:0] credit_q;

	logic              v_s1, v_s2, v_s3, v_s4;
	op_t               op_s1, op_s2, op_s3, op_s4;
	logic [31:0]       m_s1 [FIELD_COUNT];
	logic [31:0]       m_s2 [FIELD_COUNT];
	logic [31:0]       p_s3 [PROBE_COUNT];
	logic [31:0]       p_s4 [PROBE_COUNT];

	// A request is taken while fewer requests are in flight than the queue holds.
	assign busy   = (credit_q == QCNT_W'(Q_DEPTH));
	assign accept = start && !busy;

	// Classify the packet; a SYN+ACK hashes the reversed flow.
	always_comb begin
		if (!is_ipv4_tcp) begin
			op_in = OP_IGNORE;
		end else if (syn_flag && !ack_flag) begin
			op_in = OP_RECORD;
		end else if (syn_flag) begin
			op_in = OP_CHECK;
		end else begin
			op_in = OP_OTHER;
		end
		if (op_in == OP_CHECK) begin
			key_in[0] = dst_addr;
			key_in[1] = src_addr;
			key_in[2] = {dst_tcp_port, src_tcp_port};
		end else begin
			key_in[0] = src_addr;
			key_in[1] = dst_addr;
			key_in[2] = {src_tcp_port, dst_tcp_port};
		end
	end

	// Combine the mixed keys with the protocol term.
	always_comb begin
		base_hash = MIX_TCP;
		for (int k = 0; k < FIELD_COUNT; k++) begin
			base_hash = base_hash ^ mix_c(m_s2[k]);
		end
	end

	// Stage valids and credit count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			credit_q <= '0;
		end else begin
			v_s1     <= accept;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			v_s4     <= v_s3;
			credit_q <= credit_q + QCNT_W'(accept) - QCNT_W'(credit_ret);
		end
	end

	// Hash pipeline: key mix in two stages, then probe mix in two stages.
	always_ff @(posedge clk) begin
		op_s1 <= op_in;
		op_s2 <= op_s1;
		op_s3 <= op_s2;
		op_s4 <= op_s3;
		for (int k = 0; k < FIELD_COUNT; k++) begin
			m_s1[k] <= mix_a(key_in[k]);
			m_s2[k] <= mix_b(m_s1[k]);
		end
		for (int i = 0; i < PROBE_COUNT; i++) begin
			p_s3[i] <= mix_a(probe_seed(i) ^ base_hash);
			p_s4[i] <= mix_b(p_s3[i]);
		end
	end

	// Finish the probe mix and hand the request to the queue.
	always_comb begin
		push_req.op = op_s4;
		for (int i = 0; i < PROBE_COUNT; i++) begin
			push_req.bit_idx[i] = BIT_W'(mix_c(p_s4[i])) & BIT_MASK;
		end
	end

	assign push = v_s4;

endmodule

// ===== hdl/tsbt_queue.sv =====
// Short request queue between the hash front and the filter back end.
// Depends on tsbt_pkg for the request type and the depth.
module tsbt_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  tsbt_pkg::probe_req_t push_req,
	input  logic                 pop,
	output tsbt_pkg::probe_req_t head,
	output tsbt_pkg::q_status_t  q_status
);
	import tsbt_pkg::*;

	probe_req_t        entries_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head           = entries_q[rd_ptr_q];
	assign q_status.empty = (count_q == '0);
	assign q_status.full  = (count_q == QCNT_W'(Q_DEPTH));

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_req;
		end
	end

endmodule

// ===== hdl/tsbt_back.sv =====
// Back end: Bloom filter memory, read-modify-write sequencer, counters and result.
// Depends on tsbt_pkg; takes requests from tsbt_queue.
module tsbt_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tsbt_pkg::q_status_t  q_status,
	input  tsbt_pkg::probe_req_t head,
	output logic                 pop,
	output logic                 done,
	output logic [2:0]           packet_class,
	output logic [63:0]          syn_total,
	output logic [63:0]          solicited_total,
	output logic [63:0]          unsolicited_total,
	output logic [63:0]          other_total
);
	import tsbt_pkg::*;

	back_state_t          state_q, state_d;
	probe_req_t           req_q;
	logic [PROBE_W-1:0]   probe_q;
	logic                 hit_q;
	logic                 done_q;
	cls_t                 class_q;
	logic [63:0]          syn_q, sol_q, unsol_q, other_q;

	logic [63:0]          filter_mem [FILTER_WORDS];
	logic [FILTER_WORDS-1:0] valid_q;
	logic [63:0]          rd_word_q;
	logic                 rd_valid_q;

	logic [BIT_W-1:0]     cur_bit;
	logic [BIT_W-1:0]     word_full;
	logic [ADDR_W-1:0]    addr;
	logic [POS_W-1:0]     pos;
	logic                 in_range;
	logic [63:0]          word_now;
	logic [63:0]          wr_word;
	logic                 last;
	logic                 rd_en;
	logic                 wr_en;

	// Address and bit of the current probe.
	always_comb begin
		cur_bit   = req_q.bit_idx[probe_q];
		word_full = cur_bit >> POS_W;
		addr      = word_full[ADDR_W-1:0];
		pos       = cur_bit[POS_W-1:0];
		in_range  = (word_full < BIT_W'(FILTER_WORDS));
		word_now  = rd_valid_q ? rd_word_q : '0;
		wr_word   = word_now | (64'd1 << pos);
		last      = (probe_q == PROBE_W'(PROBE_COUNT - 1));
	end

	// Sequencer: one read and one merge step per probe.
	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		rd_en   = 1'b0;
		wr_en   = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (!q_status.empty) begin
					pop = 1'b1;
					if (head.op == OP_RECORD || head.op == OP_CHECK) begin
						state_d = B_READ;
					end else begin
						state_d = B_FINISH;
					end
				end
			end
			B_READ: begin
				rd_en   = in_range;
				state_d = B_MERGE;
			end
			B_MERGE: begin
				wr_en   = (req_q.op == OP_RECORD) && in_range;
				state_d = last ? B_FINISH : B_READ;
			end
			B_FINISH: begin
				state_d = B_IDLE;
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	// State, probe walk, lookup result and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			probe_q <= '0;
			hit_q   <= 1'b0;
			done_q  <= 1'b0;
			syn_q   <= '0;
			sol_q   <= '0;
			unsol_q <= '0;
			other_q <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == B_FINISH);
			if (pop) begin
				probe_q <= '0;
				hit_q   <= 1'b1;
			end
			if (state_q == B_MERGE) begin
				hit_q <= hit_q && in_range && word_now[pos];
				if (!last) begin
					probe_q <= probe_q + PROBE_W'(1);
				end
			end
			if (state_q == B_FINISH) begin
				case (req_q.op)
					OP_RECORD: syn_q <= syn_q + 64'd1;
					OP_CHECK: begin
						if (hit_q) begin
							sol_q <= sol_q + 64'd1;
						end else begin
							unsol_q <= unsol_q + 64'd1;
						end
					end
					OP_OTHER: other_q <= other_q + 64'd1;
					default: ;
				endcase
			end
		end
	end

	// Request capture and result class.
	always_ff @(posedge clk) begin
		if (pop) begin
			req_q <= head;
		end
		if (state_q == B_FINISH) begin
			case (req_q.op)
				OP_RECORD: class_q <= CLS_SYN;
				OP_CHECK:  class_q <= hit_q ? CLS_SOLICITED : CLS_UNSOLICITED;
				OP_OTHER:  class_q <= CLS_OTHER;
				default:   class_q <= CLS_IGNORED;
			endcase
		end
	end

	// Filter words with a registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			filter_mem[addr] <= wr_word;
		end
		if (rd_en) begin
			rd_word_q  <= filter_mem[addr];
			rd_valid_q <= valid_q[addr];
		end
	end

	// A word that was never written reads as cleared.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[addr] <= 1'b1;
		end
	end

	assign done              = done_q;
	assign packet_class      = class_q;
	assign syn_total         = syn_q;
	assign solicited_total   = sol_q;
	assign unsolicited_total = unsol_q;
	assign other_total       = other_q;

endmodule

// ===== sim/tcp_syn_bloom_tracker_core_tb.sv =====
// Testbench for tcp_syn_bloom_tracker_core: directed and random packet requests, each result
// checked against a behavioral model of the SYN Bloom filter and its four counters.
// Depends on tsbt_pkg and the tcp_syn_bloom_tracker_core RTL.
`timescale 1ns / 1ps

module tcp_syn_bloom_tracker_core_tb;
	import tsbt_pkg::*;

	localparam int RANDOM_TCP_ITEMS = 1290;
	localparam int STALL_LIMIT      = 1000;
	localparam int SETTLE_CYCLES    = 24;
	localparam int FLOW_POOL_MAX    = 48;

	// One packet request as the sender sees it.
	typedef struct {
		logic        valid;
		logic [31:0] sa;
		logic [31:0] da;
		logic [15:0] sp;
		logic [15:0] dp;
		logic        syn;
		logic        ack;
	} pkt_t;

	// Predicted result of one request.
	typedef struct {
		cls_t        cls;
		logic [63:0] syn_cnt;
		logic [63:0] sol_cnt;
		logic [63:0] unsol_cnt;
		logic [63:0] other_cnt;
	} tally_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        is_ipv4_tcp = 1'b0;
	logic [31:0] src_addr = '0;
	logic [31:0] dst_addr = '0;
	logic [15:0] src_tcp_port = '0;
	logic [15:0] dst_tcp_port = '0;
	logic        syn_flag = 1'b0;
	logic        ack_flag = 1'b0;
	logic        busy;
	logic        done;
	logic [2:0]  packet_class;
	logic [63:0] syn_total;
	logic [63:0] solicited_total;
	logic [63:0] unsolicited_total;
	logic [63:0] other_total;

	// Model state: the filter bits and the four counters.
	logic [FILTER_BITS-1:0] filter_bits = '0;
	logic [63:0]            syn_tally = '0;
	logic [63:0]            solicited_seen = '0;
	logic [63:0]            unsolicited_seen = '0;
	logic [63:0]            other_seen = '0;

	tally_t tally_queue[$];
	pkt_t   flow_pool[$];
	bit     failed = 1'b0;
	bit     idle_on = 1'b1;
	int     requests_taken = 0;
	int     results_seen = 0;

	tcp_syn_bloom_tracker_core i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.is_ipv4_tcp       (is_ipv4_tcp),
		.src_addr          (src_addr),
		.dst_addr          (dst_addr),
		.src_tcp_port      (src_tcp_port),
		.dst_tcp_port      (dst_tcp_port),
		.syn_flag          (syn_flag),
		.ack_flag          (ack_flag),
		.done              (done),
		.packet_class      (packet_class),
		.syn_total         (syn_total),
		.solicited_total   (solicited_total),
		.unsolicited_total (unsolicited_total),
		.other_total       (other_total)
	);

	// Free-running clock, 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// 32-bit avalanche mixer of the flow hash.
	function automatic logic [31:0] scramble32(input logic [31:0] x);
		x = x ^ (x >> 16);
		x = x * MIX_MUL_A;
		x = x ^ (x >> 15);
		x = x * MIX_MUL_B;
		x = x ^ (x >> 16);
		return x;
	endfunction

	// Filter bit selected by one probe of a flow.
	function automatic int flow_bit(input logic [31:0] sa, input logic [31:0] da,
			input logic [15:0] sp, input logic [15:0] dp, input int probe);
		logic [31:0] k;
		logic [31:0] h;
		k = 32'(probe + 1);
		h = SEED_STEP * k;
		h = h ^ scramble32(sa) ^ scramble32(da) ^ scramble32({sp, dp}) ^ scramble32(PROTO_TCP);
		h = scramble32(h);
		return int'(h & 32'(FILTER_BITS - 1));
	endfunction

	// Classify one packet, update the filter and counters, return the expected result.
	function automatic tally_t classify_packet(input pkt_t p);
		tally_t t;
		bit     hit;
		t.cls = CLS_IGNORED;
		if (p.valid) begin
			if (p.syn && !p.ack) begin
				syn_tally = syn_tally + 64'd1;
				for (int i = 0; i < PROBE_COUNT; i++)
					filter_bits[flow_bit(p.sa, p.da, p.sp, p.dp, i)] = 1'b1;
				t.cls = CLS_SYN;
			end else if (p.syn) begin
				// The answer travels the other way, so look up the reversed flow.
				hit = 1'b1;
				for (int i = 0; i < PROBE_COUNT; i++)
					if (!filter_bits[flow_bit(p.da, p.sa, p.dp, p.sp, i)])
						hit = 1'b0;
				if (hit) begin
					solicited_seen = solicited_seen + 64'd1;
					t.cls = CLS_SOLICITED;
				end else begin
					unsolicited_seen = unsolicited_seen + 64'd1;
					t.cls = CLS_UNSOLICITED;
				end
			end else begin
				other_seen = other_seen + 64'd1;
				t.cls = CLS_OTHER;
			end
		end
		t.syn_cnt   = syn_tally;
		t.sol_cnt   = solicited_seen;
		t.unsol_cnt = unsolicited_seen;
		t.other_cnt = other_seen;
		return t;
	endfunction

	function automatic pkt_t make_pkt(input logic valid, input logic [31:0] sa,
			input logic [31:0] da, input logic [15:0] sp, input logic [15:0] dp,
			input logic syn, input logic ack);
		pkt_t p;
		p.valid = valid;
		p.sa = sa;
		p.da = da;
		p.sp = sp;
		p.dp = dp;
		p.syn = syn;
		p.ack = ack;
		return p;
	endfunction

	// Random word with the extremes mixed in now and then.
	function automatic logic [31:0] pick_word();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 32'h0;
		if (r == 1)
			return 32'hffff_ffff;
		return $urandom;
	endfunction

	// Send one request; start stays high afterward so requests can go back to back.
	task automatic send_request(input pkt_t p);
		int gap;
		if (idle_on && $urandom_range(0, 99) < 33) begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start        <= 1'b1;
		is_ipv4_tcp  <= p.valid;
		src_addr     <= p.sa;
		dst_addr     <= p.da;
		src_tcp_port <= p.sp;
		dst_tcp_port <= p.dp;
		syn_flag     <= p.syn;
		ack_flag     <= p.ack;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		tally_queue.push_back(classify_packet(p));
		requests_taken++;
	endtask

	// Stop sending and wait until every predicted result has come back.
	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (tally_queue.size() != 0)
			@(posedge clk);
	endtask

	// Packets that are not IPv4 TCP must leave everything untouched.
	task automatic test_ignored_items();
		send_request(make_pkt(1'b0, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff,
			1'b1, 1'b1));
		send_request(make_pkt(1'b0, 32'h0, 32'h0, 16'h0, 16'h0, 1'b0, 1'b0));
		// An ignored SYN must not record its flow.
		send_request(make_pkt(1'b0, 32'h0a00_0001, 32'h0a00_0002, 16'h1234, 16'h0050,
			1'b1, 1'b0));
	endtask

	// A SYN records its flow; the SYN+ACK on the reversed flow is solicited.
	task automatic test_handshake_match();
		send_request(make_pkt(1'b1, 32'hc0a8_0101, 32'h0808_0808, 16'hd431, 16'h01bb,
			1'b1, 1'b0));
		send_request(make_pkt(1'b1, 32'h0808_0808, 32'hc0a8_0101, 16'h01bb, 16'hd431,
			1'b1, 1'b1));
		// Answer to the SYN that was ignored above.
		send_request(make_pkt(1'b1, 32'h0a00_0002, 32'h0a00_0001, 16'h0050, 16'h1234,
			1'b1, 1'b1));
		// Same direction as the recorded SYN instead of reversed.
		send_request(make_pkt(1'b1, 32'hc0a8_0101, 32'h0808_0808, 16'hd431, 16'h01bb,
			1'b1, 1'b1));
		// The same answer again still hits: the filter keeps its bits.
		send_request(make_pkt(1'b1, 32'h0808_0808, 32'hc0a8_0101, 16'h01bb, 16'hd431,
			1'b1, 1'b1));
	endtask

	// TCP packets without SYN count as other, whatever ACK says.
	task automatic test_other_packets();
		send_request(make_pkt(1'b1, 32'h0101_0101, 32'h0202_0202, 16'h0001, 16'h0002,
			1'b0, 1'b0));
		send_request(make_pkt(1'b1, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff,
			1'b0, 1'b1));
		send_request(make_pkt(1'b1, 32'h0, 32'h0, 16'h0, 16'h0, 1'b0, 1'b1));
	endtask

	// All-zero and all-one fields, and mixed extremes in both directions.
	task automatic test_field_extremes();
		send_request(make_pkt(1'b1, 32'h0, 32'h0, 16'h0, 16'h0, 1'b1, 1'b1));
		send_request(make_pkt(1'b1, 32'h0, 32'h0, 16'h0, 16'h0, 1'b1, 1'b0));
		send_request(make_pkt(1'b1, 32'h0, 32'h0, 16'h0, 16'h0, 1'b1, 1'b1));
		send_request(make_pkt(1'b1, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff,
			1'b1, 1'b0));
		send_request(make_pkt(1'b1, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff,
			1'b1, 1'b1));
		send_request(make_pkt(1'b1, 32'hffff_ffff, 32'h0, 16'hffff, 16'h0, 1'b1, 1'b0));
		send_request(make_pkt(1'b1, 32'h0, 32'hffff_ffff, 16'h0, 16'hffff, 1'b1, 1'b1));
	endtask

	// Start from an empty pipeline, then send a record and its answer, with a random gap allowed.
	task automatic test_drain_pause();
		wait_drained();
		send_request(make_pkt(1'b1, 32'h5555_aaaa, 32'haaaa_5555, 16'h5a5a, 16'ha5a5,
			1'b1, 1'b0));
		send_request(make_pkt(1'b1, 32'haaaa_5555, 32'h5555_aaaa, 16'ha5a5, 16'h5a5a,
			1'b1, 1'b1));
		wait_drained();
	endtask

	// Mostly handshakes from a pool of recorded flows, with noise and broken answers.
	task automatic test_random_traffic();
		pkt_t p;
		pkt_t f;
		int   r;
		int   tcp_sent;
		bit   paused;
		tcp_sent = 0;
		paused = 1'b0;
		while (tcp_sent < RANDOM_TCP_ITEMS) begin
			idle_on = !(tcp_sent >= 500 && tcp_sent < 750);
			if (tcp_sent >= 1000 && !paused) begin
				wait_drained();
				paused = 1'b1;
			end
			r = $urandom_range(0, 99);
			p = make_pkt(1'b1, pick_word(), pick_word(), 16'($urandom_range(0, 65535)),
				16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
			if (r < 10) begin
				p.valid = 1'b0;
			end else if (r < 40 || flow_pool.size() == 0) begin
				p.syn = 1'b1;
				p.ack = 1'b0;
				flow_pool.push_back(p);
				if (flow_pool.size() > FLOW_POOL_MAX)
					flow_pool.delete($urandom_range(0, flow_pool.size() - 1));
			end else if (r < 65) begin
				f = flow_pool[$urandom_range(0, flow_pool.size() - 1)];
				p = make_pkt(1'b1, f.da, f.sa, f.dp, f.sp, 1'b1, 1'b1);
			end else if (r < 75) begin
				p.syn = 1'b1;
				p.ack = 1'b1;
				if (r < 70) begin
					// Answer in the wrong direction.
					f = flow_pool[$urandom_range(0, flow_pool.size() - 1)];
					p = make_pkt(1'b1, f.sa, f.da, f.sp, f.dp, 1'b1, 1'b1);
				end
			end else begin
				p.syn = 1'b0;
				if (r < 85) begin
					f = flow_pool[$urandom_range(0, flow_pool.size() - 1)];
					p.sa = f.sa;
					p.da = f.da;
					p.sp = f.sp;
					p.dp = f.dp;
				end
			end
			send_request(p);
			if (p.valid)
				tcp_sent++;
		end
		idle_on = 1'b1;
	endtask

	// Compare each result with the oldest pending prediction.
	always @(posedge clk) begin
		tally_t t;
		if (arst_n && done) begin
			results_seen++;
			if (tally_queue.size() == 0) begin
				$display("%0t: result with no request pending, class %0d", $time, packet_class);
				failed = 1'b1;
			end else begin
				t = tally_queue.pop_front();
				if (packet_class !== t.cls) begin
					$display("%0t: packet_class expected %0d actual %0d", $time, t.cls,
						packet_class);
					failed = 1'b1;
				end
				if (syn_total !== t.syn_cnt) begin
					$display("%0t: syn_total expected %0d actual %0d", $time, t.syn_cnt,
						syn_total);
					failed = 1'b1;
				end
				if (solicited_total !== t.sol_cnt) begin
					$display("%0t: solicited_total expected %0d actual %0d", $time, t.sol_cnt,
						solicited_total);
					failed = 1'b1;
				end
				if (unsolicited_total !== t.unsol_cnt) begin
					$display("%0t: unsolicited_total expected %0d actual %0d", $time,
						t.unsol_cnt, unsolicited_total);
					failed = 1'b1;
				end
				if (other_total !== t.other_cnt) begin
					$display("%0t: other_total expected %0d actual %0d", $time, t.other_cnt,
						other_total);
					failed = 1'b1;
				end
			end
		end
	end

	// Watchdog: end the run if no request or result moves for too long.
	always @(negedge clk) begin
		static int stall_cycles = 0;
		static int last_taken = 0;
		static int last_seen = 0;
		if (requests_taken != last_taken || results_seen != last_seen)
			stall_cycles = 0;
		else
			stall_cycles++;
		last_taken = requests_taken;
		last_seen = results_seen;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Test sequence.
	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		test_ignored_items();
		test_handshake_match();
		test_other_packets();
		test_field_extremes();
		test_drain_pause();
		test_random_traffic();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (!failed)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/tsbt_pkg.sv
hdl/tsbt_front.sv
hdl/tsbt_queue.sv
hdl/tsbt_back.sv
hdl/tcp_syn_bloom_tracker_core.sv
sim/tcp_syn_bloom_tracker_core_tb.sv
